// ===== rtl/mbvb_pkg.sv =====
// ----------------------------------------------------------------------------
// mbvb_pkg
// Shared types and constants for the median-by-bisection block.
// ----------------------------------------------------------------------------
package mbvb_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned MAX_ITEMS_DEF = 4096;
  localparam logic [DATA_W-1:0] MIN_START = 32'd1000000000;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_CHECK,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } mbvb_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic scan_clr;
    logic scan;
    logic decide;
    logic emit;
  } mbvb_cmd_t;

  typedef struct packed {
    logic range_open;
    logic scan_done;
    logic stop;
    logic out_free;
  } mbvb_status_t;

endpackage

// ===== rtl/mbvb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbvb_ctrl
// Sequencer for loading, bisection passes and result hand-off.
// ----------------------------------------------------------------------------
module mbvb_ctrl import mbvb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_last_item,
  output logic         in_stall,
  input  mbvb_status_t status,
  output mbvb_cmd_t    cmd
);

  mbvb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_item) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.range_open) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = status.stop ? ST_EMIT : ST_CHECK;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/mbvb_datapath.sv =====
// ----------------------------------------------------------------------------
// mbvb_datapath
// Count store, range registers, tally counters and output register.
// ----------------------------------------------------------------------------
module mbvb_datapath import mbvb_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mbvb_cmd_t         cmd,
  output mbvb_status_t      status,
  input  logic [DATA_W-1:0] in_count_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_median_value
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  logic [DATA_W-1:0] mem [0:MAX_ITEMS-1];
  logic [DATA_W-1:0] rd_data_r;

  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     addr_r, addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]     above_r, above_nxt;
  logic [CW-1:0]     below_r, below_nxt;
  logic [DATA_W-1:0] lo_r, lo_nxt;
  logic [DATA_W-1:0] hi_r, hi_nxt;
  logic [DATA_W-1:0] med_r, med_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;

  logic              store_ok;
  logic              rd_en;
  logic [DATA_W:0]   mid_sum;
  logic              one_wide;
  logic [CW:0]       above2;
  logic [CW:0]       below2;
  logic [CW:0]       n_ext;
  logic              stop;
  logic [DATA_W-1:0] dec_lo;
  logic [DATA_W-1:0] dec_hi;
  logic [DATA_W-1:0] dec_med;
  logic [DATA_W:0]   dec_sum;

  assign store_ok = (n_r < MAX_CNT);
  assign rd_en    = cmd.scan && (addr_r < n_r);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign one_wide = ({1'b0, hi_r} == ({1'b0, lo_r} + {{DATA_W{1'b0}}, 1'b1}));
  assign above2   = {above_r, 1'b0};
  assign below2   = {below_r, 1'b0};
  assign n_ext    = {1'b0, n_r};

  always_comb begin
    stop    = 1'b0;
    dec_lo  = lo_r;
    dec_hi  = hi_r;
    dec_med = med_r;
    if (one_wide) begin
      stop = 1'b1;
      if (above2 > n_ext) begin
        dec_med = hi_r;
      end
    end else if (above_r > below_r) begin
      if (above2 < n_ext) begin
        stop = 1'b1;
      end else begin
        dec_lo = med_r;
      end
    end else if (below_r > above_r) begin
      if (below2 < n_ext) begin
        stop = 1'b1;
      end else begin
        dec_hi = med_r;
      end
    end else begin
      stop = 1'b1;
    end
    dec_sum = {1'b0, dec_lo} + {1'b0, dec_hi};
    if (!stop) begin
      dec_med = dec_sum[DATA_W:1];
    end
  end

  always_comb begin
    n_nxt         = n_r;
    addr_nxt      = addr_r;
    rd_vld_nxt    = rd_en;
    above_nxt     = above_r;
    below_nxt     = below_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    med_nxt       = med_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cmd.load && store_ok) begin
      n_nxt = n_r + CW'(1);
      if (in_count_value < lo_r) begin
        lo_nxt = in_count_value;
      end
      if (in_count_value > hi_r) begin
        hi_nxt = in_count_value;
      end
    end
    if (cmd.init) begin
      med_nxt = mid_sum[DATA_W:1];
    end
    if (cmd.scan_clr) begin
      addr_nxt  = '0;
      above_nxt = '0;
      below_nxt = '0;
    end
    if (rd_en) begin
      addr_nxt = addr_r + CW'(1);
    end
    if (rd_vld_r) begin
      if (rd_data_r > med_r) begin
        above_nxt = above_r + CW'(1);
      end
      if (rd_data_r < med_r) begin
        below_nxt = below_r + CW'(1);
      end
    end
    if (cmd.decide) begin
      lo_nxt  = dec_lo;
      hi_nxt  = dec_hi;
      med_nxt = dec_med;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = med_r;
      n_nxt         = '0;
      lo_nxt        = MIN_START;
      hi_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      mem[n_r[AW-1:0]] <= in_count_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      above_r     <= '0;
      below_r     <= '0;
      lo_r        <= MIN_START;
      hi_r        <= '0;
      med_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      above_r     <= above_nxt;
      below_r     <= below_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      med_r       <= med_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign status.range_open = (hi_r > lo_r);
  assign status.scan_done  = (addr_r == n_r) && !rd_vld_r;
  assign status.stop       = stop;
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_median_value = out_data_r;

endmodule

// ===== rtl/median_by_value_bisection.sv =====
// Loading takes one count per cycle; in_stall stays low until a last item.
// After the last item each bisection pass scans all n stored counts
// (one store read per cycle on the single read port); at most about 33
// passes run, between an init state and an emit state for the hand-off.
// Reset is synchronous: control and range registers clear, the store does not.
// ----------------------------------------------------------------------------
// median_by_value_bisection
// Median of a loaded set of counts found by bisection over the value range.
// ----------------------------------------------------------------------------
module median_by_value_bisection import mbvb_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_count_value,
  input  logic              in_last_item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_median_value
);

  mbvb_cmd_t    cmd;
  mbvb_status_t status;

  mbvb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  mbvb_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_count_value   (in_count_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_value (out_median_value)
  );

endmodule

// ===== rtl/mbvb_checker.sv =====
// ----------------------------------------------------------------------------
// mbvb_checker
// Port-level checks for the median-by-bisection block.
// ----------------------------------------------------------------------------
module mbvb_checker import mbvb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_last_item,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_median_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_median_value))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_item |=> !in_stall)
    else $error("stall raised inside a set");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_item |=> in_stall)
    else $error("input taken during bisection");

  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a finished search");

endmodule

bind median_by_value_bisection mbvb_checker u_mbvb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_last_item     (in_last_item),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_median_value (out_median_value)
);
